@@ src/asbs_pkg.sv @@
package asbs_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  localparam logic [CfgIdxW-1:0] CfgFlushThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdleLimit      = 2'd1;

  localparam logic [CountW-1:0] FlushThresholdRst = 16'd4000;
  localparam logic [CountW-1:0] IdleLimitRst      = 16'd300;
  localparam logic [CountW-1:0] IdleSat           = 16'hffff;

  localparam logic [ByteW-1:0] ChEsc      = 8'h1b;
  localparam logic [ByteW-1:0] ChDel      = 8'h7f;
  localparam logic [ByteW-1:0] ChBel      = 8'h07;
  localparam logic [ByteW-1:0] ChLf       = 8'h0a;
  localparam logic [ByteW-1:0] ChCr       = 8'h0d;
  localparam logic [ByteW-1:0] ChTab      = 8'h09;
  localparam logic [ByteW-1:0] ChSpace    = 8'h20;
  localparam logic [ByteW-1:0] ChCsiOpen  = 8'h5b;
  localparam logic [ByteW-1:0] ChOscOpen  = 8'h5d;
  localparam logic [ByteW-1:0] ChFinalLo  = 8'h40;
  localparam logic [ByteW-1:0] ChFinalHi  = 8'h7e;
  localparam logic [ByteW-1:0] ChParenL   = 8'h28;
  localparam logic [ByteW-1:0] ChParenR   = 8'h29;
  localparam logic [ByteW-1:0] ChStar     = 8'h2a;
  localparam logic [ByteW-1:0] ChPlus     = 8'h2b;
  localparam logic [ByteW-1:0] ChHash     = 8'h23;
  localparam logic [ByteW-1:0] ChEqual    = 8'h3d;
  localparam logic [ByteW-1:0] ChGreater  = 8'h3e;

  typedef struct packed {
    logic             is_tick;
    logic [ByteW-1:0] data;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_push_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

@@ src/asbs_front.sv @@
module asbs_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          func_i,
  input  logic [asbs_pkg::ByteW-1:0]    data_byte_i,
  output asbs_pkg::q_push_t             push_o
);

  localparam logic [2:0] PsNormal = 3'd0;
  localparam logic [2:0] PsEsc    = 3'd1;
  localparam logic [2:0] PsCsi    = 3'd2;
  localparam logic [2:0] PsOsc    = 3'd3;
  localparam logic [2:0] PsSkip1  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       keep;
  logic [asbs_pkg::ByteW-1:0] c;

  assign c = data_byte_i;

  always_comb begin
    state_d = state_q;
    keep    = 1'b0;
    unique case (state_q)
      PsEsc: begin
        if (c == asbs_pkg::ChCsiOpen) begin
          state_d = PsCsi;
        end else if (c == asbs_pkg::ChOscOpen) begin
          state_d = PsOsc;
        end else if (c == asbs_pkg::ChParenL || c == asbs_pkg::ChParenR ||
                     c == asbs_pkg::ChStar || c == asbs_pkg::ChPlus ||
                     c == asbs_pkg::ChHash || c == asbs_pkg::ChEqual ||
                     c == asbs_pkg::ChGreater) begin
          state_d = PsSkip1;
        end else begin
          state_d = PsNormal;
        end
      end
      PsCsi: begin
        if (c >= asbs_pkg::ChFinalLo && c <= asbs_pkg::ChFinalHi) begin
          state_d = PsNormal;
        end
      end
      PsOsc: begin
        if (c == asbs_pkg::ChBel) begin
          state_d = PsNormal;
        end else if (c == asbs_pkg::ChEsc) begin
          state_d = PsEsc;
        end
      end
      PsSkip1: begin
        state_d = PsNormal;
      end
      default: begin
        state_d = PsNormal;
        if (c == asbs_pkg::ChEsc) begin
          state_d = PsEsc;
        end else if (c < asbs_pkg::ChSpace) begin
          keep = (c == asbs_pkg::ChLf) || (c == asbs_pkg::ChCr) || (c == asbs_pkg::ChTab);
        end else begin
          keep = (c != asbs_pkg::ChDel);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PsNormal;
    end else if (accept_i && !func_i) begin
      state_q <= state_d;
    end
  end

  assign push_o.valid        = accept_i && (func_i || keep);
  assign push_o.item.is_tick = func_i;
  assign push_o.item.data    = data_byte_i;

endmodule

@@ src/asbs_queue.sv @@
module asbs_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  asbs_pkg::q_push_t push_i,
  output logic              full_o,
  output asbs_pkg::q_head_t head_o,
  input  logic              pop_i
);

  asbs_pkg::item_t                 mem_q [asbs_pkg::QDepth];
  logic [asbs_pkg::QPtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [asbs_pkg::QCntW-1:0]      cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign full_o      = (cnt_q == asbs_pkg::QCntW'(asbs_pkg::QDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.item;
    end
  end

endmodule

@@ src/asbs_back.sv @@
module asbs_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [asbs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [asbs_pkg::CountW-1:0]    cfg_data_i,
  input  asbs_pkg::q_head_t              head_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           has_byte_o,
  output logic [asbs_pkg::ByteW-1:0]     out_byte_o,
  output logic                           end_of_message_o
);

  logic [asbs_pkg::CountW-1:0] thr_q, limit_q;
  logic [asbs_pkg::CountW-1:0] pend_q, pend_d, idle_q, idle_d;
  logic [asbs_pkg::CountW-1:0] pend_inc, idle_inc;
  logic                        run_q, run_d;
  logic                        out_valid_q, out_valid_d;
  logic                        has_byte_q, has_byte_d, eom_q, eom_d;
  logic [asbs_pkg::ByteW-1:0]  byte_q, byte_d;
  logic                        slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign pop_o     = head_i.valid && slot_free;
  assign pend_inc  = pend_q + 1'b1;
  assign idle_inc  = (idle_q == asbs_pkg::IdleSat) ? idle_q : idle_q + 1'b1;

  always_comb begin
    pend_d      = pend_q;
    idle_d      = idle_q;
    run_d       = run_q;
    out_valid_d = out_valid_q;
    has_byte_d  = has_byte_q;
    byte_d      = byte_q;
    eom_d       = eom_q;
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      out_valid_d = 1'b0;
      if (!head_i.item.is_tick) begin
        out_valid_d = 1'b1;
        has_byte_d  = 1'b1;
        byte_d      = head_i.item.data;
        idle_d      = '0;
        if (pend_inc >= thr_q) begin
          pend_d = '0;
          run_d  = 1'b0;
          eom_d  = 1'b1;
        end else begin
          pend_d = pend_inc;
          run_d  = 1'b1;
          eom_d  = 1'b0;
        end
      end else if (run_q) begin
        if (idle_inc >= limit_q) begin
          run_d  = 1'b0;
          idle_d = '0;
          if (pend_q != '0) begin
            pend_d      = '0;
            out_valid_d = 1'b1;
            has_byte_d  = 1'b0;
            byte_d      = '0;
            eom_d       = 1'b1;
          end
        end else begin
          idle_d = idle_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= asbs_pkg::FlushThresholdRst;
      limit_q     <= asbs_pkg::IdleLimitRst;
      pend_q      <= '0;
      idle_q      <= '0;
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      idle_q      <= idle_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && cfg_index_i == asbs_pkg::CfgFlushThreshold) begin
        thr_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_index_i == asbs_pkg::CfgIdleLimit) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    has_byte_q <= has_byte_d;
    byte_q     <= byte_d;
    eom_q      <= eom_d;
  end

  assign out_valid_o      = out_valid_q;
  assign has_byte_o       = has_byte_q;
  assign out_byte_o       = byte_q;
  assign end_of_message_o = eom_q;

endmodule

@@ src/ansi_strip_batching_stream_top.sv @@
// A kept byte or an expiring tick is written into the queue and then registered in the output stage.
// Throughput: one item per cycle while the queue is not full; the escape parser and the batch counter
// each update at most once per cycle, and a two-entry queue between them absorbs output stalls.
// Reset: parser returns to normal text, counters, idle timer and queue clear, the batch
// limit register becomes 4000 and idle_limit 300.
module ansi_strip_batching_stream_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic [asbs_pkg::ByteW-1:0]    data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          has_byte_o,
  output logic [asbs_pkg::ByteW-1:0]    out_byte_o,
  output logic                          end_of_message_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [asbs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [asbs_pkg::CountW-1:0]   cfg_data_i
);

  asbs_pkg::q_push_t push;
  asbs_pkg::q_head_t head;
  logic              q_full, pop, accept;

  assign in_stall_o  = q_full;
  assign accept      = in_valid_i && !q_full;
  assign cfg_ready_o = 1'b1;

  asbs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .func_i      (func_i),
    .data_byte_i (data_byte_i),
    .push_o      (push)
  );

  asbs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .head_o (head),
    .pop_i  (pop)
  );

  asbs_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .has_byte_o       (has_byte_o),
    .out_byte_o       (out_byte_o),
    .end_of_message_o (end_of_message_o)
  );

endmodule

@@ verif/asbs_batch_checker.sv @@
module asbs_batch_checker
  import asbs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               func_i,
  input  logic [ByteW-1:0]   data_byte_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               has_byte_i,
  input  logic [ByteW-1:0]   out_byte_i,
  input  logic               end_of_message_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CountW-1:0]  cfg_data_i,
  output int                 error_count_o,
  output int                 open_count_o
);

  localparam int PrintCap = 50;

  typedef enum logic [2:0] {
    ScanText = 3'd0,
    ScanEsc  = 3'd1,
    ScanCsi  = 3'd2,
    ScanOsc  = 3'd3,
    ScanSkip = 3'd4
  } scan_e;

  typedef struct packed {
    logic             has_byte;
    logic [ByteW-1:0] data;
    logic             eom;
  } batch_out_t;

  scan_e             scan;
  logic [CountW-1:0] kept;
  logic [CountW-1:0] idle_ticks;
  logic              timer_on;
  logic [CountW-1:0] threshold;
  logic [CountW-1:0] idle_lim;
  batch_out_t        expected_q[$];
  int                errors = 0;

  task automatic report(input string msg);
    if (errors < PrintCap) begin
      $display("%0t mismatch: %s", $realtime, msg);
    end
    errors++;
  endtask

  task automatic absorb_item(input logic is_tick, input logic [ByteW-1:0] c);
    logic keep;
    keep = 1'b0;
    if (!is_tick) begin
      case (scan)
        ScanEsc: begin
          if (c == ChCsiOpen) scan = ScanCsi;
          else if (c == ChOscOpen) scan = ScanOsc;
          else if (c inside {ChParenL, ChParenR, ChStar, ChPlus, ChHash, ChEqual, ChGreater})
            scan = ScanSkip;
          else scan = ScanText;
        end
        ScanCsi: begin
          if (c >= ChFinalLo && c <= ChFinalHi) scan = ScanText;
        end
        ScanOsc: begin
          if (c == ChBel) scan = ScanText;
          else if (c == ChEsc) scan = ScanEsc;
        end
        ScanSkip: begin
          scan = ScanText;
        end
        default: begin
          scan = ScanText;
          if (c == ChEsc) scan = ScanEsc;
          else if (c < ChSpace) keep = c inside {ChLf, ChCr, ChTab};
          else keep = (c != ChDel);
        end
      endcase
      if (keep) begin
        kept = kept + 1'b1;
        idle_ticks = '0;
        if (kept >= threshold) begin
          kept = '0;
          timer_on = 1'b0;
          expected_q.push_back('{has_byte: 1'b1, data: c, eom: 1'b1});
        end else begin
          timer_on = 1'b1;
          expected_q.push_back('{has_byte: 1'b1, data: c, eom: 1'b0});
        end
      end
    end else if (timer_on) begin
      if (idle_ticks != IdleSat) idle_ticks = idle_ticks + 1'b1;
      if (idle_ticks >= idle_lim) begin
        timer_on = 1'b0;
        idle_ticks = '0;
        if (kept != '0) begin
          kept = '0;
          expected_q.push_back('{has_byte: 1'b0, data: '0, eom: 1'b1});
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    batch_out_t want;
    if (!rst_ni) begin
      scan = ScanText;
      kept = '0;
      idle_ticks = '0;
      timer_on = 1'b0;
      threshold = FlushThresholdRst;
      idle_lim = IdleLimitRst;
      expected_q.delete();
      open_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report($sformatf("unexpected transfer has_byte=%0b byte=%02h eom=%0b",
                           has_byte_i, out_byte_i, end_of_message_i));
        end else begin
          want = expected_q.pop_front();
          if (has_byte_i !== want.has_byte)
            report($sformatf("has_byte got %0b want %0b", has_byte_i, want.has_byte));
          if (out_byte_i !== want.data)
            report($sformatf("out_byte got %02h want %02h", out_byte_i, want.data));
          if (end_of_message_i !== want.eom)
            report($sformatf("end_of_message got %0b want %0b (byte %02h)",
                             end_of_message_i, want.eom, want.data));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgFlushThreshold) threshold = cfg_data_i;
        else if (cfg_index_i == CfgIdleLimit) idle_lim = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) absorb_item(func_i, data_byte_i);
      open_count_o <= expected_q.size();
    end
    error_count_o <= errors;
  end

endmodule

@@ verif/ansi_strip_batching_stream_top_tb.sv @@
module ansi_strip_batching_stream_top_tb;
  import asbs_pkg::*;

  localparam logic               FuncByte      = 1'b0;
  localparam logic               FuncTick      = 1'b1;
  localparam logic [CfgIdxW-1:0] CfgSpare      = 2'd3;
  localparam int                 HoldCycles    = 80;
  localparam int                 SettleCycles  = 8;
  localparam int                 WatchdogLimit = 1000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               func_i;
  logic [ByteW-1:0]   data_byte_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               has_byte_o;
  logic [ByteW-1:0]   out_byte_o;
  logic               end_of_message_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CountW-1:0]  cfg_data_i;

  int mismatches;
  int open_results;
  int sent;
  int quiet_cycles = 0;
  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  ansi_strip_batching_stream_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .func_i           (func_i),
    .data_byte_i      (data_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .has_byte_o       (has_byte_o),
    .out_byte_o       (out_byte_o),
    .end_of_message_o (end_of_message_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  asbs_batch_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .func_i           (func_i),
    .data_byte_i      (data_byte_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .has_byte_i       (has_byte_o),
    .out_byte_i       (out_byte_o),
    .end_of_message_i (end_of_message_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .error_count_o    (mismatches),
    .open_count_o     (open_results)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("ansi_strip_batching_stream_top_tb: errors");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_done <= 1'b1;
        @(posedge clk_i);
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  task automatic send_item(input logic tick, input logic [ByteW-1:0] c);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    func_i      <= tick;
    data_byte_i <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CountW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (open_results != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_batching(input logic [CountW-1:0] thr, input logic [CountW-1:0] lim);
    write_reg(CfgFlushThreshold, thr);
    write_reg(CfgIdleLimit, lim);
    write_reg(CfgSpare, CountW'($urandom_range(0, 65535)));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic emit_sequence();
    int kind;
    logic [ByteW-1:0] pick;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 1) == 0) send_item(FuncByte, ByteW'($urandom_range(32, 126)));
        else send_item(FuncByte, ByteW'($urandom_range(128, 255)));
      end
    end else if (kind < 43) begin
      case ($urandom_range(0, 2))
        0: pick = ChLf;
        1: pick = ChCr;
        default: pick = ChTab;
      endcase
      send_item(FuncByte, pick);
    end else if (kind < 53) begin
      send_item(FuncByte, ChEsc);
      send_item(FuncByte, ChCsiOpen);
      repeat ($urandom_range(0, 4)) send_item(FuncByte, ByteW'($urandom_range(8'h30, 8'h3f)));
      send_item(FuncByte, ByteW'($urandom_range(ChFinalLo, ChFinalHi)));
    end else if (kind < 60) begin
      send_item(FuncByte, ChEsc);
      send_item(FuncByte, ChOscOpen);
      repeat ($urandom_range(0, 5)) send_item(FuncByte, ByteW'($urandom_range(8'h20, 8'h7e)));
      if ($urandom_range(0, 1) == 0) begin
        send_item(FuncByte, ChBel);
      end else begin
        send_item(FuncByte, ChEsc);
        send_item(FuncByte, 8'h5c);
      end
    end else if (kind < 66) begin
      case ($urandom_range(0, 6))
        0: pick = ChParenL;
        1: pick = ChParenR;
        2: pick = ChStar;
        3: pick = ChPlus;
        4: pick = ChHash;
        5: pick = ChEqual;
        default: pick = ChGreater;
      endcase
      send_item(FuncByte, ChEsc);
      send_item(FuncByte, pick);
      send_item(FuncByte, ByteW'($urandom_range(0, 255)));
    end else if (kind < 82) begin
      repeat ($urandom_range(1, 12)) send_item(FuncTick, ByteW'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 2) == 0) send_item(FuncByte, ChEsc);
      repeat ($urandom_range(1, 3)) send_item(FuncByte, ByteW'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_phase(input logic [CountW-1:0] thr, input logic [CountW-1:0] lim,
                           input int items, input bit gaps, input bit stalls,
                           input bit pressure);
    int stop_at;
    drain();
    set_batching(thr, lim);
    gaps_on   <= gaps;
    stalls_on <= stalls;
    if (pressure) hold_req <= 1'b1;
    stop_at = sent + items;
    while (sent < stop_at) emit_sequence();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    func_i      = FuncByte;
    data_byte_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgFlushThreshold;
    cfg_data_i  = '0;
    sent        = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values of both registers
    gaps_on   <= 1'b1;
    stalls_on <= 1'b1;
    while (sent < 60) emit_sequence();

    drain();
    set_batching(16'd4, 16'd2);
    send_item(FuncTick, 8'h5a);
    send_item(FuncByte, 8'h41);
    send_item(FuncByte, 8'h00);
    send_item(FuncByte, ChDel);
    send_item(FuncByte, ChLf);
    send_item(FuncByte, ChCr);
    send_item(FuncByte, ChTab);
    send_item(FuncByte, 8'hff);
    send_item(FuncTick, 8'hff);
    send_item(FuncTick, 8'h00);
    send_item(FuncByte, ChEsc);
    send_item(FuncByte, ChCsiOpen);
    send_item(FuncByte, 8'h31);
    send_item(FuncByte, ChFinalHi);
    send_item(FuncByte, ChEsc);
    send_item(FuncByte, ChOscOpen);
    send_item(FuncByte, 8'h61);
    send_item(FuncByte, ChBel);
    send_item(FuncByte, ChEsc);
    send_item(FuncByte, ChOscOpen);
    send_item(FuncByte, ChEsc);
    send_item(FuncByte, 8'h5c);
    send_item(FuncByte, ChEsc);
    send_item(FuncByte, ChParenL);
    send_item(FuncByte, 8'h42);
    send_item(FuncByte, ChEsc);
    send_item(FuncByte, 8'h63);
    send_item(FuncByte, ChSpace);

    run_phase(16'd1, 16'd1, 120, 1'b1, 1'b1, 1'b0);
    run_phase(16'hffff, 16'hffff, 100, 1'b1, 1'b0, 1'b0);
    run_phase(16'd7, 16'd3, 150, 1'b0, 1'b1, 1'b0);
    run_phase(16'd30, 16'd10, 150, 1'b0, 1'b1, 1'b1);
    run_phase(16'd3, 16'd2, 120, 1'b1, 1'b1, 1'b0);
    run_phase(16'd12, 16'd4, 100, 1'b0, 1'b0, 1'b0);

    drain();
    if (mismatches == 0) begin
      $display("ansi_strip_batching_stream_top_tb: clean");
    end else begin
      $display("ansi_strip_batching_stream_top_tb: errors");
    end
    $finish;
  end

endmodule
